// ----- design/lkdw_pkg.sv -----
// Shared types and constants for the longest-K-distinct window unit.
// No dependencies; imported by every module of the block but lkdw_ram.
package lkdw_pkg;

   localparam int SYM_W    = 8;
   localparam int NUM_SYMS = 256;
   localparam int K_W      = 9;
   localparam int BEST_W   = 11;

   localparam logic [K_W-1:0]    K_RESET  = 9'd3;
   localparam logic [BEST_W-1:0] BEST_MAX = 11'd2047;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_ADD_RD   = 7'b0000010,
      ST_ADD      = 7'b0000100,
      ST_DROP_RD  = 7'b0001000,
      ST_DROP_CNT = 7'b0010000,
      ST_DROP_WR  = 7'b0100000,
      ST_WAIT     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [BEST_W-1:0] best_length;
      logic              found;
      logic              overflow;
   } result_type;

endpackage

// ----- design/lkdw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the count store and the window ring.
module lkdw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- design/lkdw_core.sv -----
// Window sequencer: count memory, window ring and the read-modify-write control.
// Depends on lkdw_pkg and lkdw_ram.
module lkdw_core
   import lkdw_pkg::*;
#(
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [K_W-1:0]   unique_required,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_start_new,
   input  logic             out_free,
   output logic             res_valid,
   output result_type       res
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int LW = $clog2(WINDOW_DEPTH + 1);
   localparam int PW = LW + 1;
   localparam int CA = $clog2(NUM_SYMS);

   state_type          state_ff, state_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [SYM_W-1:0]   drop_sym_ff, drop_sym_in;
   logic               pre_drop_ff, pre_drop_in;
   logic               ring_fwd_ff, ring_fwd_in;
   logic [AW-1:0]      start_ff, start_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [K_W-1:0]     dist_ff, dist_in;
   logic [LW-1:0]      best_ff, best_in;
   logic               found_ff, found_in;
   logic               ovf_ff, ovf_in;
   logic [NUM_SYMS-1:0] cnt_valid_ff;
   logic [CA-1:0]      cnt_raddr_ff;

   logic               cnt_rd_en, cnt_wr_en;
   logic [CA-1:0]      cnt_rd_addr, cnt_wr_addr;
   logic [LW-1:0]      cnt_wr_data, cnt_rd_data, cnt_cur;
   logic               ring_rd_en, ring_wr_en;
   logic [AW-1:0]      ring_rd_addr;
   logic [SYM_W-1:0]   ring_rd_data, ring_sym;
   logic               clear_valid;

   logic [PW-1:0]      pos_sum;
   logic [AW-1:0]      pos, start_inc;
   logic [K_W-1:0]     dist_nx;
   logic [LW-1:0]      len_nx;
   logic               finish;
   logic [BEST_W-1:0]  best_sat;

   lkdw_ram #(.WIDTH(LW), .DEPTH(NUM_SYMS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   lkdw_ram #(.WIDTH(SYM_W), .DEPTH(WINDOW_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (pos),
      .wr_data (sym_ff),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   assign cnt_cur   = cnt_valid_ff[cnt_raddr_ff] ? cnt_rd_data : '0;
   assign ring_sym  = ring_fwd_ff ? sym_ff : ring_rd_data;
   assign pos_sum   = PW'(start_ff) + PW'(len_ff);
   assign pos       = (pos_sum >= PW'(WINDOW_DEPTH)) ? AW'(pos_sum - PW'(WINDOW_DEPTH))
                                                     : AW'(pos_sum);
   assign start_inc = (start_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : start_ff + AW'(1);

   always_comb begin
      state_in    = state_ff;
      sym_in      = sym_ff;
      drop_sym_in = drop_sym_ff;
      pre_drop_in = pre_drop_ff;
      ring_fwd_in = ring_fwd_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      dist_in     = dist_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      ovf_in      = ovf_ff;
      dist_nx     = dist_ff;
      len_nx      = len_ff;
      finish      = 1'b0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      clear_valid = 1'b0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = sym_ff;
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = sym_ff;
      cnt_wr_data = cnt_cur + LW'(1);
      ring_rd_en  = 1'b0;
      ring_rd_addr = start_ff;
      ring_wr_en  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sym_in      = req_symbol;
               cnt_rd_en   = 1'b1;
               cnt_rd_addr = req_symbol;
               if (req_start_new) begin
                  clear_valid = 1'b1;
                  start_in    = '0;
                  len_in      = '0;
                  dist_in     = '0;
                  best_in     = '0;
                  found_in    = 1'b0;
                  ovf_in      = 1'b0;
                  state_in    = ST_ADD;
               end else if (len_ff == LW'(WINDOW_DEPTH)) begin
                  ovf_in      = 1'b1;
                  pre_drop_in = 1'b1;
                  state_in    = ST_DROP_RD;
               end else begin
                  state_in    = ST_ADD;
               end
            end
         end
         ST_ADD_RD: begin
            cnt_rd_en = 1'b1;
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            cnt_wr_en   = 1'b1;
            ring_wr_en  = 1'b1;
            ring_rd_en  = 1'b1;
            ring_fwd_in = (len_ff == '0);
            dist_nx     = (cnt_cur == '0) ? dist_ff + K_W'(1) : dist_ff;
            len_nx      = len_ff + LW'(1);
            dist_in     = dist_nx;
            len_in      = len_nx;
            if (dist_nx > unique_required && len_nx != '0) begin
               state_in = ST_DROP_CNT;
            end else begin
               finish = 1'b1;
            end
         end
         ST_DROP_RD: begin
            ring_rd_en  = 1'b1;
            ring_fwd_in = 1'b0;
            state_in    = ST_DROP_CNT;
         end
         ST_DROP_CNT: begin
            cnt_rd_en    = 1'b1;
            cnt_rd_addr  = ring_sym;
            drop_sym_in  = ring_sym;
            ring_rd_en   = 1'b1;
            ring_rd_addr = start_inc;
            ring_fwd_in  = 1'b0;
            state_in     = ST_DROP_WR;
         end
         ST_DROP_WR: begin
            cnt_wr_addr = drop_sym_ff;
            cnt_wr_data = cnt_cur - LW'(1);
            cnt_wr_en   = (cnt_cur != '0);
            dist_nx     = (cnt_cur == LW'(1) && dist_ff != '0) ? dist_ff - K_W'(1) : dist_ff;
            len_nx      = len_ff - LW'(1);
            dist_in     = dist_nx;
            len_in      = len_nx;
            start_in    = start_inc;
            if (pre_drop_ff) begin
               pre_drop_in = 1'b0;
               state_in    = ST_ADD_RD;
            end else if (dist_nx > unique_required && len_nx != '0) begin
               state_in = ST_DROP_CNT;
            end else begin
               finish = 1'b1;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         if (dist_nx == unique_required) begin
            found_in = 1'b1;
            if (len_nx > best_ff) begin
               best_in = len_nx;
            end
         end
         if (out_free) begin
            res_valid = 1'b1;
            state_in  = ST_IDLE;
         end else begin
            state_in  = ST_WAIT;
         end
      end
   end

   if (LW > BEST_W) begin : g_sat
      assign best_sat = (best_in > LW'(BEST_MAX)) ? BEST_MAX : best_in[BEST_W-1:0];
   end else begin : g_ext
      assign best_sat = BEST_W'(best_in);
   end

   assign res.best_length = best_sat;
   assign res.found       = found_in;
   assign res.overflow    = ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pre_drop_ff <= 1'b0;
         ring_fwd_ff <= 1'b0;
         start_ff    <= '0;
         len_ff      <= '0;
         dist_ff     <= '0;
         best_ff     <= '0;
         found_ff    <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pre_drop_ff <= pre_drop_in;
         ring_fwd_ff <= ring_fwd_in;
         start_ff    <= start_in;
         len_ff      <= len_in;
         dist_ff     <= dist_in;
         best_ff     <= best_in;
         found_ff    <= found_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_valid) begin
         cnt_valid_ff <= '0;
      end else if (cnt_wr_en) begin
         cnt_valid_ff[cnt_wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      drop_sym_ff <= drop_sym_in;
      if (cnt_rd_en) begin
         cnt_raddr_ff <= cnt_rd_addr;
      end
   end

endmodule

// ----- design/longest_k_distinct_window_unit.sv -----
// Top level of the longest-K-distinct window unit: K register, response register.
// Depends on lkdw_pkg and lkdw_core (which holds the two RAMs).
//
// Each request carries one symbol and returns one response with the best window
// length having exactly K distinct symbols, a found flag and a sticky overflow
// flag. A request with no window shrink does a count read, then a count and ring
// write; every symbol dropped from the window's left end adds a count read and
// a count write, using the symbol read from the ring, and a request on a full
// ring first forces a drop (ring read, count read, count write, count re-read).
// Each symbol is dropped at most once. The response register lets the next
// request enter while a response waits. The user must write K via
// csr_wr_en/csr_wr_data only while the unit is idle; not enforced in the block.
module longest_k_distinct_window_unit
   import lkdw_pkg::*;
#(
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_start_new,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BEST_W-1:0] rsp_best_length,
   output logic              rsp_found,
   output logic              rsp_overflow,
   input  logic              csr_wr_en,
   input  logic [K_W-1:0]    csr_wr_data
);

   logic [K_W-1:0] k_ff;
   logic           rsp_valid_ff;
   result_type     rsp_ff;
   result_type     res;
   logic           res_valid;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   lkdw_core #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_core (
      .clock           (clock),
      .reset           (reset),
      .unique_required (k_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol      (req_symbol),
      .req_start_new   (req_start_new),
      .out_free        (out_free),
      .res_valid       (res_valid),
      .res             (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
      end else if (csr_wr_en) begin
         k_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_length = rsp_ff.best_length;
   assign rsp_found       = rsp_ff.found;
   assign rsp_overflow    = rsp_ff.overflow;

endmodule

// ----- design/lkdw_checker.sv -----
// Port-level checks for the longest-K-distinct window unit, bound to the top level.
// Depends on lkdw_pkg and longest_k_distinct_window_unit.
module lkdw_checker
   import lkdw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BEST_W-1:0] rsp_best_length,
   input logic              rsp_found,
   input logic              rsp_overflow
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_length)
         && $stable(rsp_found) && $stable(rsp_overflow))
      else $error("response changed while stalled");

   a_best_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_best_length == '0)
      else $error("best length nonzero before found");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many requests in flight");

endmodule

bind longest_k_distinct_window_unit lkdw_checker u_lkdw_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking bench for longest_k_distinct_window_unit: directed table, then random strings.
// Depends on lkdw_pkg and the unit; keeps its own sliding-window model of the expected responses.
module testbench;
   import lkdw_pkg::*;

   localparam int WINDOW_DEPTH = 1024;
   localparam int NUM_ROWS     = 26;
   localparam int NUM_PHASES   = 10;
   localparam int PHASE_ITEMS  = 20;
   localparam int CFG_SETTLE   = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum logic {ROW_SEND, ROW_SET_K} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [K_W-1:0]    k_value;
      logic [SYM_W-1:0]  symbol;
      logic              start_new;
      logic [10:0]       reps;
      logic [SYM_W-1:0]  stride;
      logic              has_result;
      result_type        result;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [SYM_W-1:0]  req_symbol;
   logic              req_start_new;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BEST_W-1:0] rsp_best_length;
   logic              rsp_found;
   logic              rsp_overflow;
   logic              csr_wr_en;
   logic [K_W-1:0]    csr_wr_data;

   // window model
   logic [K_W-1:0]    required_distinct;
   logic [10:0]       symbol_tally [NUM_SYMS];
   logic [K_W-1:0]    distinct_syms;
   logic [SYM_W-1:0]  window_syms [WINDOW_DEPTH];
   logic [9:0]        window_head;
   logic [10:0]       window_len;
   logic [BEST_W-1:0] longest_len;
   logic              k_window_seen;
   logic              ring_overflowed;

   result_type        expected_windows [$];
   result_type        next_expected;
   stim_row_type      directed_rows [NUM_ROWS];
   int unsigned       src_idle_pct;
   int unsigned       sink_idle_pct;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;

   longest_k_distinct_window_unit #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol      (req_symbol),
      .req_start_new   (req_start_new),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_best_length (rsp_best_length),
      .rsp_found       (rsp_found),
      .rsp_overflow    (rsp_overflow),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic void clear_window();
      for (int s = 0; s < NUM_SYMS; s++) symbol_tally[s] = '0;
      distinct_syms   = '0;
      window_head     = '0;
      window_len      = '0;
      longest_len     = '0;
      k_window_seen   = 1'b0;
      ring_overflowed = 1'b0;
   endfunction

   function automatic void drop_oldest_symbol();
      logic [SYM_W-1:0] s;
      if (window_len == 0) return;
      s = window_syms[window_head];
      if (symbol_tally[s] != 0) begin
         symbol_tally[s] = symbol_tally[s] - 11'd1;
         if (symbol_tally[s] == 0 && distinct_syms != 0) distinct_syms = distinct_syms - 9'd1;
      end
      window_head = 10'((int'(window_head) + 1) % WINDOW_DEPTH);
      window_len  = window_len - 11'd1;
   endfunction

   function automatic result_type advance_window(input logic [SYM_W-1:0] sym, input logic st);
      result_type res;
      int         pos;
      if (st) clear_window();
      if (int'(window_len) >= WINDOW_DEPTH) begin
         ring_overflowed = 1'b1;
         drop_oldest_symbol();
      end
      pos = (int'(window_head) + int'(window_len)) % WINDOW_DEPTH;
      window_syms[pos] = sym;
      window_len = window_len + 11'd1;
      if (symbol_tally[sym] == 0) distinct_syms = distinct_syms + 9'd1;
      symbol_tally[sym] = symbol_tally[sym] + 11'd1;
      while (distinct_syms > required_distinct && window_len != 0) drop_oldest_symbol();
      if (distinct_syms == required_distinct) begin
         k_window_seen = 1'b1;
         if (window_len > longest_len) longest_len = window_len;
      end
      res.best_length = (longest_len > BEST_MAX) ? BEST_MAX : longest_len;
      res.found       = k_window_seen;
      res.overflow    = ring_overflowed;
      return res;
   endfunction

   task automatic send_request(input logic [SYM_W-1:0] sym, input logic st,
                               input logic use_given, input result_type given);
      result_type predicted;
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_symbol    <= sym;
      req_start_new <= st;
      do @(posedge clock); while (!req_ready);
      predicted = advance_window(sym, st);
      expected_windows.push_back(use_given ? given : predicted);
   endtask

   task automatic program_k(input logic [K_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_windows.size() != 0) @(posedge clock);
      repeat (CFG_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      required_distinct = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               $display("%0t: unexpected response best_length %0d found %0b overflow %0b",
                        $time, rsp_best_length, rsp_found, rsp_overflow);
               mismatch_count++;
            end else begin
               next_expected = expected_windows.pop_front();
               if (rsp_best_length !== next_expected.best_length) begin
                  $display("%0t: best_length expected %0d actual %0d",
                           $time, next_expected.best_length, rsp_best_length);
                  mismatch_count++;
               end
               if (rsp_found !== next_expected.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, next_expected.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_overflow !== next_expected.overflow) begin
                  $display("%0t: overflow expected %0b actual %0b",
                           $time, next_expected.overflow, rsp_overflow);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      stim_row_type     row;
      logic [K_W-1:0]   kv;
      logic [SYM_W-1:0] sym;
      logic [SYM_W-1:0] base;
      logic             st;
      int               idx;
      int               rep;
      int               phase;
      int               remaining;
      int               str_len;
      int               alpha;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_symbol    <= '0;
      req_start_new <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      required_distinct = K_RESET;
      clear_window();
      src_idle_pct  = 16;
      sink_idle_pct = 58;

      directed_rows = '{
         '{ROW_SEND,  9'd0,   8'h00, 1'b1, 11'd1,    8'd0, 1'b1, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'hFF, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h80, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd3,    1'b1, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h80, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd4,    1'b1, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h01, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd4,    1'b1, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h7F, 1'b1, 11'd1,    8'd0, 1'b1, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SET_K, 9'd1,   8'h00, 1'b0, 11'd0,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'hAA, 1'b1, 11'd1,    8'd0, 1'b1, '{11'd1,    1'b1, 1'b0}},
         '{ROW_SEND,  9'd0,   8'hAA, 1'b0, 11'd1023, 8'd0, 1'b1, '{11'd1024, 1'b1, 1'b0}},
         '{ROW_SEND,  9'd0,   8'hAA, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd1024, 1'b1, 1'b1}},
         '{ROW_SEND,  9'd0,   8'h55, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd1024, 1'b1, 1'b1}},
         '{ROW_SEND,  9'd0,   8'h33, 1'b1, 11'd1,    8'd0, 1'b1, '{11'd1,    1'b1, 1'b0}},
         '{ROW_SET_K, 9'd0,   8'h00, 1'b0, 11'd0,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h12, 1'b1, 11'd1,    8'd0, 1'b1, '{11'd0,    1'b1, 1'b0}},
         '{ROW_SEND,  9'd0,   8'hFE, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd0,    1'b1, 1'b0}},
         '{ROW_SET_K, 9'd511, 8'h00, 1'b0, 11'd0,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h00, 1'b1, 11'd4,    8'd1, 1'b1, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'hF0, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SET_K, 9'd256, 8'h00, 1'b0, 11'd0,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h00, 1'b1, 11'd256,  8'd1, 1'b1, '{11'd256,  1'b1, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h07, 1'b0, 11'd1,    8'd0, 1'b1, '{11'd257,  1'b1, 1'b0}},
         '{ROW_SET_K, 9'd2,   8'h00, 1'b0, 11'd0,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h10, 1'b1, 11'd1,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h20, 1'b0, 11'd1,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h10, 1'b0, 11'd1,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}},
         '{ROW_SEND,  9'd0,   8'h30, 1'b0, 11'd1,    8'd0, 1'b0, '{11'd0,    1'b0, 1'b0}}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (idx = 0; idx < NUM_ROWS; idx++) begin
         row = directed_rows[idx];
         if (row.kind == ROW_SET_K) begin
            program_k(row.k_value);
         end else begin
            for (rep = 0; rep < int'(row.reps); rep++) begin
               send_request(SYM_W'(int'(row.symbol) + rep * int'(row.stride)),
                            row.start_new && rep == 0,
                            row.has_result && rep == int'(row.reps) - 1, row.result);
            end
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: kv = 9'd1;
            1: kv = 9'd2;
            2: kv = K_W'($urandom_range(3, 16));
            3: kv = 9'd255;
            4: kv = 9'd256;
            5: kv = 9'd0;
            6: kv = 9'd511;
            7: kv = K_W'($urandom_range(0, 511));
            8: kv = 9'd3;
            default: kv = K_W'($urandom_range(1, 8));
         endcase
         if (phase == 4) begin
            src_idle_pct  = 58;
            sink_idle_pct = 16;
         end else if (phase == 7) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         program_k(kv);
         remaining = PHASE_ITEMS;
         while (remaining > 0) begin
            str_len = (kv <= 16) ? $urandom_range(4, 60) : $urandom_range(20, 125);
            if (str_len > remaining) str_len = remaining;
            if (kv == 0) alpha = 1;
            else if (kv <= 16) alpha = $urandom_range(int'(kv), int'(kv) + 3);
            else alpha = NUM_SYMS;
            base = SYM_W'($urandom_range(0, 255));
            for (rep = 0; rep < str_len; rep++) begin
               if ($urandom_range(0, 9) == 0) sym = SYM_W'($urandom_range(0, 255));
               else sym = SYM_W'(int'(base) + $urandom_range(0, alpha - 1));
               st = (rep == 0) || ($urandom_range(0, 99) == 0);
               send_request(sym, st, 1'b0, '0);
            end
            remaining -= str_len;
         end
      end

      // drain outstanding responses
      req_valid <= 1'b0;
      while (expected_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
